// File: design/rgb_to_yuv420_converter_unit_macros.svh
// Assertion macros for the RGB to YUV 4:2:0 converter.
// Included by the top level; no other dependencies.
`ifndef RGB_TO_YUV420_CONVERTER_UNIT_MACROS_SVH
`define RGB_TO_YUV420_CONVERTER_UNIT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define RYUV_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("ryuv: invariant violated");

// When the trigger holds, the consequence must hold in the same cycle.
`define RYUV_ASSERT_SAME(lbl, clk, rst, trig, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
      else $error("ryuv: same-cycle implication violated");

// When the trigger holds, the consequence must hold in the next cycle.
`define RYUV_ASSERT_NEXT(lbl, clk, rst, trig, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("ryuv: next-cycle implication violated");

`endif

// File: design/ryuv_pkg.sv
// Shared types and constants for the RGB to YUV 4:2:0 converter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ryuv_pkg;

   // Port widths.
   localparam int PIX_W      = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int ROW_W      = 11;

   // Geometry defaults and limits.
   localparam int MAX_WIDTH_DEFAULT = 2048;
   localparam int HEIGHT_LIMIT      = 2048;
   localparam int WIDTH_RESET       = 640;
   localparam int HEIGHT_RESET      = 480;
   // Wide enough for any clamped width (up to 8192) and any register value.
   localparam int CMP_W             = 14;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PIXEL_FORMAT = 2'd0,
      REG_FRAME_WIDTH  = 2'd1,
      REG_FRAME_HEIGHT = 2'd2
   } reg_index_type;

   // RGB555 field masks.
   localparam logic [15:0] RGB555_RED_MASK   = 16'h7C00;
   localparam logic [15:0] RGB555_GREEN_MASK = 16'h03E0;
   localparam logic [15:0] RGB555_BLUE_MASK  = 16'h001F;

   // Fixed-point arithmetic, coefficients scaled by 2^23.
   localparam int COEF_W  = 23;
   localparam int PROD_W  = 31;
   localparam int SUM_W   = 33;
   localparam int NUM_PROD = 9;
   localparam int SHIFT_555 = 20;
   localparam int SHIFT_888 = 23;
   localparam logic [7:0] OFFSET_Y = 8'd16;
   localparam logic [7:0] OFFSET_C = 8'd128;

   // Coefficient magnitudes in the order Y(r,g,b), U(r,g,b), V(r,g,b).
   localparam logic [COEF_W-1:0] COEF [NUM_PROD] = '{
      23'd2155872, 23'd4227858, 23'd822083,
      23'd1241513, 23'd2441084, 23'd3682598,
      23'd3682598, 23'd3087007, 23'd595591
   };

   // Position of a pixel in the 2x2 chroma block, carried down the pipeline.
   typedef struct packed {
      logic col_odd;
      logic row_odd;
      logic last;
   } ctrl_type;

endpackage

// File: design/ryuv_color.sv
// Color-space stage pair: constant products, then sums, shift, offset, clip.
// Depends on ryuv_pkg for coefficients and widths.
`timescale 1ns / 1ps

module ryuv_color (
   input  logic                           clock,
   input  logic                           load_prod,
   input  logic                           load_yuv,
   input  logic                           pixel_format,
   input  logic [ryuv_pkg::PIX_W-1:0]     pixel_data,
   output logic [7:0]                     luma,
   output logic [7:0]                     chroma_u,
   output logic [7:0]                     chroma_v
);

   logic [2:0][7:0]                                     comp;
   logic [ryuv_pkg::NUM_PROD-1:0][ryuv_pkg::PROD_W-1:0] prod_in;
   logic [ryuv_pkg::NUM_PROD-1:0][ryuv_pkg::PROD_W-1:0] prod_ff;
   logic signed [ryuv_pkg::SUM_W-1:0]                   ys;
   logic signed [ryuv_pkg::SUM_W-1:0]                   us;
   logic signed [ryuv_pkg::SUM_W-1:0]                   vs;
   logic signed [ryuv_pkg::SUM_W-1:0]                   ys_sh;
   logic signed [ryuv_pkg::SUM_W-1:0]                   us_sh;
   logic signed [ryuv_pkg::SUM_W-1:0]                   vs_sh;
   logic [7:0]                                          y_in;
   logic [7:0]                                          u_in;
   logic [7:0]                                          v_in;
   logic [7:0]                                          y_ff;
   logic [7:0]                                          u_ff;
   logic [7:0]                                          v_ff;

   // Add the offset and saturate to 0..255.
   function automatic logic [7:0] clip_offset(input logic signed [ryuv_pkg::SUM_W-1:0] x,
                                              input logic [7:0] offset);
      logic signed [ryuv_pkg::SUM_W-1:0] t;
      t = x + $signed({{(ryuv_pkg::SUM_W-8){1'b0}}, offset});
      if (t < 0) begin
         return 8'd0;
      end else if (t > $signed(ryuv_pkg::SUM_W'(255))) begin
         return 8'd255;
      end else begin
         return t[7:0];
      end
   endfunction

   // Component unpacking; RGB555 fields are zero-extended to 8 bits.
   always_comb begin
      if (pixel_format) begin
         comp[0] = pixel_data[23:16];
         comp[1] = pixel_data[15:8];
         comp[2] = pixel_data[7:0];
      end else begin
         comp[0] = 8'((pixel_data[15:0] & ryuv_pkg::RGB555_RED_MASK) >> 10);
         comp[1] = 8'((pixel_data[15:0] & ryuv_pkg::RGB555_GREEN_MASK) >> 5);
         comp[2] = 8'(pixel_data[15:0] & ryuv_pkg::RGB555_BLUE_MASK);
      end
   end

   // One constant multiplier per coefficient; component k%3 is r, g or b.
   for (genvar k = 0; k < ryuv_pkg::NUM_PROD; k++) begin : g_prod
      assign prod_in[k] = ryuv_pkg::PROD_W'(comp[k % 3]) *
                          ryuv_pkg::PROD_W'(ryuv_pkg::COEF[k]);
   end

   always_ff @(posedge clock) begin
      if (load_prod) begin
         prod_ff <= prod_in;
      end
   end

   // Signed sums of the registered products.
   always_comb begin
      ys = $signed({2'b00, prod_ff[0]}) + $signed({2'b00, prod_ff[1]})
         + $signed({2'b00, prod_ff[2]});
      us = $signed({2'b00, prod_ff[5]}) - $signed({2'b00, prod_ff[3]})
         - $signed({2'b00, prod_ff[4]});
      vs = $signed({2'b00, prod_ff[6]}) - $signed({2'b00, prod_ff[7]})
         - $signed({2'b00, prod_ff[8]});
   end

   // Floor by arithmetic shift: 23 for 8-bit components, 20 for 5-bit ones.
   assign ys_sh = pixel_format ? (ys >>> ryuv_pkg::SHIFT_888) : (ys >>> ryuv_pkg::SHIFT_555);
   assign us_sh = pixel_format ? (us >>> ryuv_pkg::SHIFT_888) : (us >>> ryuv_pkg::SHIFT_555);
   assign vs_sh = pixel_format ? (vs >>> ryuv_pkg::SHIFT_888) : (vs >>> ryuv_pkg::SHIFT_555);

   assign y_in = clip_offset(ys_sh, ryuv_pkg::OFFSET_Y);
   assign u_in = clip_offset(us_sh, ryuv_pkg::OFFSET_C);
   assign v_in = clip_offset(vs_sh, ryuv_pkg::OFFSET_C);

   always_ff @(posedge clock) begin
      if (load_yuv) begin
         y_ff <= y_in;
         u_ff <= u_in;
         v_ff <= v_in;
      end
   end

   assign luma     = y_ff;
   assign chroma_u = u_ff;
   assign chroma_v = v_ff;

endmodule

// File: design/ryuv_chroma.sv
// Chroma subsampling: horizontal pair sums, line store of even-row sums,
// and the 2x2 average on odd-row, odd-column pixels. Depends on ryuv_pkg.
`timescale 1ns / 1ps

module ryuv_chroma #(
   parameter int MAX_WIDTH = ryuv_pkg::MAX_WIDTH_DEFAULT,
   parameter int SLOT_W    = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_read,
   input  logic [SLOT_W-1:0]     read_slot,
   input  logic                  load_out,
   input  ryuv_pkg::ctrl_type    ctrl,
   input  logic [SLOT_W-1:0]     slot,
   input  logic [7:0]            pixel_u,
   input  logic [7:0]            pixel_v,
   output logic [7:0]            chroma_u,
   output logic [7:0]            chroma_v,
   output logic                  chroma_valid
);

   localparam int LINE_DEPTH = MAX_WIDTH / 2;

   logic [17:0] pair_line_ff [LINE_DEPTH];
   logic [17:0] line_rd_ff;
   logic [15:0] hold_ff;
   logic [8:0]  sum_u;
   logic [8:0]  sum_v;
   logic [9:0]  quad_u;
   logic [9:0]  quad_v;
   logic        line_wr;

   // Registered read for the item moving into the stage before the result register.
   always_ff @(posedge clock) begin
      if (load_read) begin
         line_rd_ff <= pair_line_ff[read_slot];
      end
   end

   // Even rows store their pair sums on the odd column.
   assign line_wr = load_out && ctrl.col_odd && !ctrl.row_odd;

   always_ff @(posedge clock) begin
      if (line_wr) begin
         pair_line_ff[slot] <= {sum_u, sum_v};
      end
   end

   // Chroma of the even-column pixel, held for its odd neighbor.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= '0;
      end else if (load_out && !ctrl.col_odd) begin
         hold_ff <= {pixel_u, pixel_v};
      end
   end

   // Horizontal sums, then the four-pixel sums with the row above.
   assign sum_u  = {1'b0, hold_ff[15:8]} + {1'b0, pixel_u};
   assign sum_v  = {1'b0, hold_ff[7:0]} + {1'b0, pixel_v};
   assign quad_u = {1'b0, line_rd_ff[17:9]} + {1'b0, sum_u};
   assign quad_v = {1'b0, line_rd_ff[8:0]} + {1'b0, sum_v};

   // Average with truncation; zero where no block ends.
   assign chroma_valid = ctrl.col_odd && ctrl.row_odd;
   assign chroma_u     = chroma_valid ? quad_u[9:2] : 8'd0;
   assign chroma_v     = chroma_valid ? quad_v[9:2] : 8'd0;

endmodule

// File: design/rgb_to_yuv420_converter_unit.sv
// Channel  Handshake          Payload
// req      req_valid/stall    req_pixel_data (24)
// rsp      rsp_valid/stall    rsp_luma, rsp_chroma_u, rsp_chroma_v (8 each),
//                             rsp_chroma_valid, rsp_frame_last
// csr      csr_valid/ready    csr_index (2), csr_wdata (12)
//
// One pixel per cycle sustained while rsp_stall is low; each result passes the stages below in order.
// Stages: input register, coefficient products, YUV with line-store read,
// result register. Each stage moves up when the one after it is free or moves.
// Reset is synchronous; the line store is not cleared and needs no pass.
// Stall on rsp fills the stages and then raises req_stall.
// Depends on ryuv_pkg, ryuv_color, ryuv_chroma and the macros header.
`timescale 1ns / 1ps
`include "rgb_to_yuv420_converter_unit_macros.svh"

module rgb_to_yuv420_converter_unit #(
   parameter int MAX_WIDTH = ryuv_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ryuv_pkg::PIX_W-1:0]        req_pixel_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_luma,
   output logic [7:0]                        rsp_chroma_u,
   output logic [7:0]                        rsp_chroma_v,
   output logic                              rsp_chroma_valid,
   output logic                              rsp_frame_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ryuv_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ryuv_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int SLOT_W = (CW > 1) ? CW - 1 : 1;

   // Configuration registers.
   logic                              pixel_format_ff;
   logic [ryuv_pkg::CSR_DATA_W-1:0]   frame_width_ff;
   logic [ryuv_pkg::CSR_DATA_W-1:0]   frame_height_ff;

   // Raster counters.
   logic [CW-1:0]                     col_ff;
   logic [CW-1:0]                     col_in;
   logic [ryuv_pkg::ROW_W-1:0]        row_ff;
   logic [ryuv_pkg::ROW_W-1:0]        row_in;
   logic [ryuv_pkg::CMP_W-1:0]        width_even;
   logic [ryuv_pkg::CMP_W-1:0]        width_eff;
   logic [ryuv_pkg::CMP_W-1:0]        col_plus;
   logic [ryuv_pkg::CSR_DATA_W-1:0]   height_eff;
   logic [ryuv_pkg::ROW_W:0]          row_plus;
   logic                              col_wrap;
   logic                              row_wrap;
   logic                              at_last;
   logic [SLOT_W-1:0]                 cur_slot;
   ryuv_pkg::ctrl_type                cur_ctrl;

   // Pipeline control.
   logic v1_ff, v2_ff, v3_ff, vo_ff;
   logic v1_in, v2_in, v3_in, vo_in;
   logic free1, free2, free3, adv_out;
   logic accept, load2, load3, load_out;

   // Stage payload.
   logic [ryuv_pkg::PIX_W-1:0]        pix1_ff;
   ryuv_pkg::ctrl_type                ctrl1_ff, ctrl2_ff, ctrl3_ff;
   logic [SLOT_W-1:0]                 slot1_ff, slot2_ff, slot3_ff;
   logic [7:0]                        y3, u3, v3;
   logic [7:0]                        cu, cv;
   logic                              cvalid;

   // Result register.
   logic [7:0]                        luma_ff, chroma_u_ff, chroma_v_ff;
   logic                              chroma_valid_ff, frame_last_ff;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= 1'b0;
         frame_width_ff  <= ryuv_pkg::CSR_DATA_W'(ryuv_pkg::WIDTH_RESET);
         frame_height_ff <= ryuv_pkg::CSR_DATA_W'(ryuv_pkg::HEIGHT_RESET);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ryuv_pkg::REG_PIXEL_FORMAT: pixel_format_ff <= csr_wdata[0];
            ryuv_pkg::REG_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            ryuv_pkg::REG_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective geometry: even width clamped to 2..MAX_WIDTH, height to 2..limit.
   assign width_even = ryuv_pkg::CMP_W'({frame_width_ff[ryuv_pkg::CSR_DATA_W-1:1], 1'b0});

   always_comb begin
      if (width_even < ryuv_pkg::CMP_W'(2)) begin
         width_eff = ryuv_pkg::CMP_W'(2);
      end else if (width_even > ryuv_pkg::CMP_W'(MAX_WIDTH)) begin
         width_eff = ryuv_pkg::CMP_W'(MAX_WIDTH);
      end else begin
         width_eff = width_even;
      end
      if (frame_height_ff < ryuv_pkg::CSR_DATA_W'(2)) begin
         height_eff = ryuv_pkg::CSR_DATA_W'(2);
      end else if (frame_height_ff > ryuv_pkg::CSR_DATA_W'(ryuv_pkg::HEIGHT_LIMIT)) begin
         height_eff = ryuv_pkg::CSR_DATA_W'(ryuv_pkg::HEIGHT_LIMIT);
      end else begin
         height_eff = frame_height_ff;
      end
   end

   // Counter advance; a counter at or past its limit wraps to zero.
   assign col_plus = ryuv_pkg::CMP_W'(col_ff) + ryuv_pkg::CMP_W'(1);
   assign col_wrap = col_plus >= width_eff;
   assign row_plus = {1'b0, row_ff} + {{ryuv_pkg::ROW_W{1'b0}}, 1'b1};
   assign row_wrap = ryuv_pkg::CSR_DATA_W'(row_plus) >= height_eff;
   assign at_last  = col_wrap && row_wrap;
   assign col_in   = col_wrap ? '0 : col_plus[CW-1:0];
   assign row_in   = col_wrap ? (row_wrap ? '0 : row_plus[ryuv_pkg::ROW_W-1:0]) : row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line-store slot of the current column pair.
   if (CW > 1) begin : g_slot
      assign cur_slot = col_ff[CW-1:1];
   end else begin : g_slot_one
      assign cur_slot = '0;
   end

   assign cur_ctrl.col_odd = col_ff[0];
   assign cur_ctrl.row_odd = row_ff[0];
   assign cur_ctrl.last    = at_last;

   // Each stage loads when it is empty or its contents move on.
   assign adv_out   = !vo_ff || !rsp_stall;
   assign free3     = !v3_ff || adv_out;
   assign free2     = !v2_ff || free3;
   assign free1     = !v1_ff || free2;
   assign req_stall = !free1;
   assign accept    = req_valid && !req_stall;
   assign load2     = v1_ff && free2;
   assign load3     = v2_ff && free3;
   assign load_out  = v3_ff && adv_out;

   assign v1_in = accept   || (v1_ff && !free2);
   assign v2_in = load2    || (v2_ff && !free3);
   assign v3_in = load3    || (v3_ff && !adv_out);
   assign vo_in = load_out || (vo_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         vo_ff <= vo_in;
      end
   end

   // Position information travels alongside the pixel.
   always_ff @(posedge clock) begin
      if (accept) begin
         pix1_ff  <= req_pixel_data;
         ctrl1_ff <= cur_ctrl;
         slot1_ff <= cur_slot;
      end
      if (load2) begin
         ctrl2_ff <= ctrl1_ff;
         slot2_ff <= slot1_ff;
      end
      if (load3) begin
         ctrl3_ff <= ctrl2_ff;
         slot3_ff <= slot2_ff;
      end
   end

   ryuv_color u_color (
      .clock        (clock),
      .load_prod    (load2),
      .load_yuv     (load3),
      .pixel_format (pixel_format_ff),
      .pixel_data   (pix1_ff),
      .luma         (y3),
      .chroma_u     (u3),
      .chroma_v     (v3)
   );

   ryuv_chroma #(
      .MAX_WIDTH (MAX_WIDTH),
      .SLOT_W    (SLOT_W)
   ) u_chroma (
      .clock        (clock),
      .reset        (reset),
      .load_read    (load3),
      .read_slot    (slot2_ff),
      .load_out     (load_out),
      .ctrl         (ctrl3_ff),
      .slot         (slot3_ff),
      .pixel_u      (u3),
      .pixel_v      (v3),
      .chroma_u     (cu),
      .chroma_v     (cv),
      .chroma_valid (cvalid)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (load_out) begin
         luma_ff         <= y3;
         chroma_u_ff     <= cu;
         chroma_v_ff     <= cv;
         chroma_valid_ff <= cvalid;
         frame_last_ff   <= ctrl3_ff.last;
      end
   end

   assign rsp_valid        = vo_ff;
   assign rsp_luma         = luma_ff;
   assign rsp_chroma_u     = chroma_u_ff;
   assign rsp_chroma_v     = chroma_v_ff;
   assign rsp_chroma_valid = chroma_valid_ff;
   assign rsp_frame_last   = frame_last_ff;

   // The input side stalls only when every stage holds a pixel and the output waits.
   `RYUV_ASSERT_SAME(a_stall_full, clock, reset, req_stall,
                     v1_ff && v2_ff && v3_ff && vo_ff && rsp_stall)

   // The pixel that ends a frame returns both counters to the origin.
   `RYUV_ASSERT_NEXT(a_frame_wrap, clock, reset, accept && at_last,
                     col_ff == '0 && row_ff == '0)

   // Chroma fields read zero on results that end no 2x2 block.
   `RYUV_ASSERT_SAME(a_chroma_zero, clock, reset, rsp_valid && !rsp_chroma_valid,
                     rsp_chroma_u == 8'd0 && rsp_chroma_v == 8'd0)

endmodule
